[hdl/eat_pkg.sv]
// -----------------------------------------------------------------------------
// Emergency action table package
// Shared types and fixed codes for the emergency action table.
// -----------------------------------------------------------------------------
package eat_pkg;

  // Input operation codes.
  localparam logic [2:0] OP_SET      = 3'd0;
  localparam logic [2:0] OP_PERIODIC = 3'd1;
  localparam logic [2:0] OP_CLEAR    = 3'd2;
  localparam logic [2:0] OP_RAISE_RC = 3'd3;
  localparam logic [2:0] OP_RAISE_GC = 3'd4;

  // Flight mode codes. Any other code counts as "other".
  localparam logic [1:0] NAV_RC  = 2'd1;
  localparam logic [1:0] NAV_GCS = 2'd2;

  localparam logic [7:0] HOLD_FOREVER = 8'hFF;
  localparam logic [7:0] GRADE_GATE   = 8'd2;

  // Bit positions inside entry_flags.
  localparam int FLAG_ACTIVE   = 0;
  localparam int FLAG_FINISHED = 1;
  localparam int FLAG_HOVER    = 2;
  localparam int FLAG_HOME     = 3;
  localparam int FLAG_LAND     = 4;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_HOVER = 2'd1,
    CMD_HOME  = 2'd2,
    CMD_LAND  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHOOSE
  } state_t;

  // One table entry as kept in the entry memory.
  typedef struct packed {
    logic       hover;
    logic       home;
    logic       land;
    logic [7:0] hold;
    logic [7:0] grade;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result word.
  typedef struct packed {
    cmd_t        command;
    logic [7:0]  alert_level;
    logic [15:0] active_mask;
    logic        clear_done;
  } result_t;

endpackage

[hdl/eat_if.sv]
// -----------------------------------------------------------------------------
// Emergency action table channels
// Valid/ready channels for input words and result words.
// -----------------------------------------------------------------------------
interface eat_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [3:0] entry_index;
  logic [4:0] entry_flags;
  logic [7:0] hold_time;
  logic [7:0] grade;
  logic       second_tick;
  logic [1:0] nav_mode;
  logic       task_normal;
  logic       in_flight;

  modport source (
    output valid, op, entry_index, entry_flags, hold_time, grade,
           second_tick, nav_mode, task_normal, in_flight,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, entry_flags, hold_time, grade,
           second_tick, nav_mode, task_normal, in_flight,
    output ready
  );
endinterface

interface eat_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  alert_level;
  logic [15:0] active_mask;
  logic        clear_done;

  modport source (
    output valid, command, alert_level, active_mask, clear_done,
    input  ready
  );
  modport sink (
    input  valid, command, alert_level, active_mask, clear_done,
    output ready
  );
endinterface

[hdl/eat_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module eat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/eat_out_buf.sv]
// -----------------------------------------------------------------------------
// Result buffer
// Output register plus one skid word, so a new input word can be taken while
// a finished result still waits on the output.
// -----------------------------------------------------------------------------
module eat_out_buf import eat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fin_valid,
  input  result_t           fin,
  output logic              space,
  eat_out_if.source         out_ch
);

  logic    out_valid_r;
  result_t out_r;
  logic    skid_valid_r;
  result_t skid_r;

  // The skid word is only filled by a result whose input was taken while it
  // was empty, so a free skid word is enough room for one more input word.
  assign space = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r  <= skid_valid_r || fin_valid;
      skid_valid_r <= 1'b0;
    end else if (fin_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_r <= skid_valid_r ? skid_r : fin;
    end else if (fin_valid) begin
      skid_r <= fin;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.command     = out_r.command;
  assign out_ch.alert_level = out_r.alert_level;
  assign out_ch.active_mask = out_r.active_mask;
  assign out_ch.clear_done  = out_r.clear_done;

endmodule

[hdl/emergency_action_table.sv]
// -----------------------------------------------------------------------------
// Emergency action table
// Table of emergency entries with hover countdown, alert summary and command
// choice. Entry payloads live in a RAM; active and finished marks in flops.
// -----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Word
//   in_ch     input      valid/ready    op, entry_index, entry_flags,
//                                       hold_time, grade, second_tick,
//                                       nav_mode, task_normal, in_flight
//   out_ch    output     valid/ready    command, alert_level, active_mask,
//                                       clear_done
//
// Set, clear, raise and unknown words finish in the cycle they are taken.
// A periodic word walks the entry RAM one entry per cycle, set by the single
// read port of the entry RAM, and then picks the command.
// Reset (synchronous, active low) clears all marks, pending interrupts, the
// command and the summary; the entry RAM needs no clearing pass since an
// entry is only looked at once a set word has written it.
// in_ch.ready is low while a periodic walk runs or while both the output
// register and the skid word hold results.
//
module emergency_action_table import eat_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  eat_in_if.sink     in_ch,
  eat_out_if.source  out_ch
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Control state.
  state_t              state_r, state_nxt;
  logic [ENTRIES-1:0]  active_r, active_nxt;
  logic [ENTRIES-1:0]  finished_r, finished_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic                rc_r, rc_nxt;
  logic                gcs_r, gcs_nxt;
  logic [7:0]          level_r, level_nxt;
  logic [15:0]         mask_r, mask_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  // Periodic word fields held for the walk, and the walk's accumulators.
  logic                tick_r, tick_nxt;
  logic [1:0]          nav_r, nav_nxt;
  logic                task_r, task_nxt;
  logic [7:0]          acc_level_r, acc_level_nxt;
  logic                acc_land_r, acc_land_nxt;
  logic                acc_home_r, acc_home_nxt;
  logic                acc_hover_r, acc_hover_nxt;

  // Handshake and memory signals.
  logic                space;
  logic                accept;
  logic                fin_valid;
  result_t             fin;
  logic                clear_done;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [IW-1:0]       ram_raddr;
  entry_t              ram_rdata;

  // Entry being processed: the one read in the previous walk cycle.
  logic [CW-1:0]       pidx_full;
  logic [IW-1:0]       pidx;
  logic                proc_en;
  logic                p_act;
  logic                p_live;
  logic                p_hover;
  logic [7:0]          p_hold;
  logic                p_fin;
  logic                p_count;

  // Index of a set word at table width.
  logic [IW+3:0]       set_wide;
  logic [IW-1:0]       set_idx;
  logic                set_ok;

  assign accept    = in_ch.valid && in_ch.ready;
  assign set_wide  = {{IW{1'b0}}, in_ch.entry_index};
  assign set_idx   = set_wide[IW-1:0];
  assign set_ok    = (int'(in_ch.entry_index) < ENTRIES) &&
                     !active_r[set_idx] && !finished_r[set_idx];

  assign pidx_full = cnt_r - CW'(1);
  assign pidx      = pidx_full[IW-1:0];
  assign proc_en   = (state_r == ST_SCAN) && (cnt_r != '0);

  // Hover countdown of one entry, taken from the RAM read data.
  always_comb begin
    p_act   = active_r[pidx];
    p_live  = p_act && !finished_r[pidx];
    p_count = tick_r && p_live;
    p_hover = ram_rdata.hover;
    p_hold  = ram_rdata.hold;
    if (p_count && ram_rdata.hover) begin
      if (ram_rdata.hold != 8'd0 && ram_rdata.hold != HOLD_FOREVER) begin
        p_hold = ram_rdata.hold - 8'd1;
      end
      if (p_hold == 8'd0) begin
        p_hover = 1'b0;
      end
    end
    p_fin = finished_r[pidx] ||
            (p_count && !p_hover && !ram_rdata.home && !ram_rdata.land);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.op == OP_PERIODIC) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(ENTRIES)) begin
          state_nxt = ST_CHOOSE;
        end
      end
      ST_CHOOSE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs: handshake, result strobe and memory ports.
  always_comb begin
    in_ch.ready = 1'b0;
    fin_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = set_idx;
    ram_wdata   = '{hover: in_ch.entry_flags[FLAG_HOVER],
                    home:  in_ch.entry_flags[FLAG_HOME],
                    land:  in_ch.entry_flags[FLAG_LAND],
                    hold:  in_ch.hold_time,
                    grade: in_ch.grade};
    ram_raddr   = cnt_r[IW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = space;
        fin_valid   = accept && (in_ch.op != OP_PERIODIC);
        ram_we      = accept && (in_ch.op == OP_SET) && set_ok;
      end
      ST_SCAN: begin
        ram_we    = proc_en && p_count;
        ram_waddr = pidx;
        ram_wdata = '{hover: p_hover, home: ram_rdata.home, land: ram_rdata.land,
                      hold: p_hold, grade: ram_rdata.grade};
      end
      ST_CHOOSE: fin_valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    active_nxt    = active_r;
    finished_nxt  = finished_r;
    cmd_nxt       = cmd_r;
    rc_nxt        = rc_r;
    gcs_nxt       = gcs_r;
    level_nxt     = level_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    nav_nxt       = nav_r;
    task_nxt      = task_r;
    acc_level_nxt = acc_level_r;
    acc_land_nxt  = acc_land_r;
    acc_home_nxt  = acc_home_r;
    acc_hover_nxt = acc_hover_r;
    clear_done    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            OP_SET: begin
              if (set_ok) begin
                active_nxt[set_idx]   = in_ch.entry_flags[FLAG_ACTIVE];
                finished_nxt[set_idx] = in_ch.entry_flags[FLAG_FINISHED];
              end
            end
            OP_PERIODIC: begin
              cnt_nxt       = '0;
              tick_nxt      = in_ch.second_tick;
              nav_nxt       = in_ch.nav_mode;
              task_nxt      = in_ch.task_normal;
              acc_level_nxt = 8'd0;
              acc_land_nxt  = 1'b0;
              acc_home_nxt  = 1'b0;
              acc_hover_nxt = 1'b0;
            end
            OP_CLEAR: begin
              // Clearing is refused while airborne.
              if (!in_ch.in_flight) begin
                active_nxt = '0;
                clear_done = 1'b1;
              end
            end
            OP_RAISE_RC: rc_nxt  = 1'b1;
            OP_RAISE_GC: gcs_nxt = 1'b1;
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (proc_en) begin
          finished_nxt[pidx] = p_fin;
          if (p_act && ram_rdata.grade > acc_level_r) begin
            acc_level_nxt = ram_rdata.grade;
          end
          if (p_act && !p_fin) begin
            if (!p_hover && !ram_rdata.home && ram_rdata.land) acc_land_nxt = 1'b1;
            if (!p_hover && ram_rdata.home) acc_home_nxt = 1'b1;
            if (p_hover) acc_hover_nxt = 1'b1;
          end
        end
      end

      ST_CHOOSE: begin
        level_nxt = acc_level_r;
        mask_nxt  = '0;
        for (int b = 0; b < 16; b++) begin
          if (b < ENTRIES) begin
            mask_nxt[b] = active_r[b];
          end
        end
        // An interrupt in the matching flight mode finishes every active
        // entry and drops the command; otherwise a low grade with the task
        // not running, or a land already under way, keeps the command.
        if ((nav_r == NAV_RC && rc_r) || (nav_r == NAV_GCS && gcs_r)) begin
          finished_nxt = finished_r | active_r;
          cmd_nxt      = CMD_NONE;
          rc_nxt       = 1'b0;
          gcs_nxt      = 1'b0;
        end else if (!task_r && acc_level_r <= GRADE_GATE) begin
          cmd_nxt = cmd_r;
        end else if (cmd_r == CMD_LAND) begin
          cmd_nxt = cmd_r;
        end else if (acc_land_r) begin
          cmd_nxt = CMD_LAND;
        end else if (acc_home_r) begin
          cmd_nxt = CMD_HOME;
        end else if (acc_hover_r) begin
          cmd_nxt = CMD_HOVER;
        end else begin
          cmd_nxt = CMD_NONE;
        end
      end

      default: ;
    endcase
  end

  assign fin = '{command:     cmd_nxt,
                 alert_level: level_nxt,
                 active_mask: mask_nxt,
                 clear_done:  clear_done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= '0;
      finished_r <= '0;
      cmd_r      <= CMD_NONE;
      rc_r       <= 1'b0;
      gcs_r      <= 1'b0;
      level_r    <= 8'd0;
      mask_r     <= 16'd0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      finished_r <= finished_nxt;
      cmd_r      <= cmd_nxt;
      rc_r       <= rc_nxt;
      gcs_r      <= gcs_nxt;
      level_r    <= level_nxt;
      mask_r     <= mask_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r      <= tick_nxt;
    nav_r       <= nav_nxt;
    task_r      <= task_nxt;
    acc_level_r <= acc_level_nxt;
    acc_land_r  <= acc_land_nxt;
    acc_home_r  <= acc_home_nxt;
    acc_hover_r <= acc_hover_nxt;
  end

  eat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  eat_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin       (fin),
    .space     (space),
    .out_ch    (out_ch)
  );

endmodule
